// ===== rtl/core/dnlc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dnlc_pkg
// Shared types, constants and the hash permutation of the directory name
// lookup cache.
// ----------------------------------------------------------------------------
package dnlc_pkg;

    localparam int NUM_SETS_DEF = 256;
    localparam int NUM_WAYS_DEF = 3;
    localparam int MAX_NAME     = 15;
    localparam int CHAR_SLOTS   = 15;
    localparam int HASH_STEPS   = (CHAR_SLOTS + 1) / 2;
    localparam int SUM_BITS     = 32;

    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_ENTER  = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;
    localparam logic [1:0] ACT_PURGE  = 2'd3;

    localparam logic [15:0] CHAR_LOWER_A = 16'h0061;
    localparam logic [15:0] CHAR_LOWER_Z = 16'h007a;
    localparam logic [15:0] CHAR_FOLD    = 16'h0020;

    localparam logic [7:0] REG_CASE_FOLD = 8'd0;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] volume_id;
        logic [31:0] dir_ino;
        logic [7:0]  name_len;
        logic [63:0] name_w0;
        logic [63:0] name_w1;
        logic [63:0] name_w2;
        logic [47:0] name_w3;
        logic [31:0] new_ino;
    } in_item_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] found_ino;
    } out_item_t;

    typedef logic [CHAR_SLOTS-1:0][15:0] name_t;

    typedef struct packed {
        logic [1:0]  action;
        logic        ignore;
        logic [31:0] volume;
        logic [31:0] dir;
        logic [3:0]  len;
        name_t       chars;
        logic [31:0] new_ino;
    } req_t;

    typedef struct packed {
        logic [31:0] volume;
        logic [31:0] dir;
        logic [31:0] ino;
        logic [3:0]  len;
        name_t       chars;
    } way_t;

    localparam logic [7:0] PERM [256] = '{
        8'h8d,8'h23,8'h12,8'h6b,8'h4b,8'h1f,8'h4e,8'h05,8'h54,8'hcb,8'hbd,8'hd4,8'hb3,8'h69,8'he1,8'h91,
        8'h7e,8'haf,8'h31,8'h6e,8'h56,8'h72,8'h83,8'h8a,8'h67,8'h66,8'h36,8'h96,8'haa,8'h42,8'h73,8'h3d,
        8'h29,8'hc1,8'hde,8'he8,8'ha7,8'hfd,8'ha1,8'hd8,8'h1e,8'h41,8'h13,8'h2f,8'h37,8'hae,8'hb4,8'h97,
        8'hda,8'h6c,8'h75,8'hfc,8'hcc,8'he3,8'h7d,8'h76,8'h8e,8'h02,8'ha0,8'h61,8'h8f,8'h63,8'h17,8'h0f,
        8'hee,8'h8c,8'h78,8'h4d,8'hf7,8'hfa,8'hc4,8'h48,8'h6a,8'h53,8'h86,8'h38,8'hdc,8'h08,8'h4f,8'hc8,
        8'hff,8'h21,8'hf8,8'h5e,8'hea,8'h07,8'h28,8'h7f,8'h58,8'h93,8'h2e,8'hc5,8'h8b,8'h4c,8'h50,8'hcd,
        8'hb6,8'h99,8'h2b,8'h80,8'h74,8'hd3,8'hf9,8'hbc,8'ha8,8'h9f,8'h20,8'h34,8'hc2,8'hd0,8'h22,8'h33,
        8'hd6,8'h01,8'he7,8'h3c,8'ha9,8'h79,8'h1d,8'h81,8'h9c,8'he5,8'hbe,8'h95,8'h89,8'h3e,8'hc9,8'hb1,
        8'h46,8'h5f,8'h88,8'h87,8'h45,8'hef,8'hac,8'had,8'h6f,8'hb2,8'h47,8'hf6,8'hf2,8'ha2,8'h5a,8'h18,
        8'hb8,8'h9a,8'he9,8'h2d,8'h39,8'h15,8'h59,8'h5b,8'h98,8'h1b,8'h16,8'hc0,8'hb7,8'ha5,8'h24,8'hce,
        8'h06,8'h25,8'h0a,8'h51,8'h70,8'hdd,8'hed,8'h40,8'h71,8'hd1,8'h3f,8'h1a,8'h03,8'hc3,8'hfb,8'hbf,
        8'hcf,8'h0e,8'h94,8'hdb,8'hca,8'he0,8'h27,8'hf0,8'hf3,8'h11,8'h5c,8'hc6,8'h9d,8'hbb,8'h35,8'h85,
        8'hab,8'h14,8'h77,8'hf5,8'hd5,8'hec,8'h30,8'hb0,8'h6d,8'ha3,8'h65,8'hba,8'hb5,8'hc7,8'h9e,8'h3a,
        8'h04,8'h4a,8'h44,8'h90,8'hdf,8'h7a,8'h92,8'hf1,8'h0b,8'he2,8'ha6,8'h7c,8'h60,8'h0c,8'h55,8'h0d,
        8'h57,8'h2a,8'h9b,8'h84,8'hf4,8'h19,8'hd2,8'h10,8'h7b,8'he4,8'h62,8'hd7,8'h00,8'h5d,8'he6,8'h2c,
        8'h49,8'h09,8'h43,8'h68,8'h52,8'hd9,8'h3b,8'h1c,8'h32,8'hfe,8'heb,8'h82,8'h26,8'hb9,8'h64,8'ha4
    };

endpackage
`default_nettype wire

// ===== rtl/core/dnlc_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dnlc_fifo
// Two-entry register queue between stages.
// ----------------------------------------------------------------------------
module dnlc_fifo
#(
    parameter int WIDTH = 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             rd,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wp_reg;
    logic             rp_reg;
    logic [1:0]       cnt_reg;
    logic             do_wr;
    logic             do_rd;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign rdata = slot_reg[rp_reg];
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= !wp_reg;
            end
            if (do_rd)
            begin
                rp_reg <= !rp_reg;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/dnlc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dnlc_front
// Accepts requests, folds case, hashes the name and reduces it to a set.
// ----------------------------------------------------------------------------
module dnlc_front
    import dnlc_pkg::*;
#(
    parameter int NUM_SETS = NUM_SETS_DEF,
    parameter int SW       = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    case_fold,
    input  wire logic    push,
    input  wire in_item_t req,
    output logic         full,
    output logic         q_push,
    output req_t         q_req,
    output logic [SW-1:0] q_set,
    input  wire logic    q_full
);

    localparam int          SET_L     = $clog2(NUM_SETS);
    localparam int          RECIP_SH  = (SET_L > 0) ? SET_L - 1 : 0;
    localparam int          MOD_STEPS = 3;
    localparam logic [31:0] RECIP_M   = 32'((((64'd1 << 32) * ((64'd1 << SET_L)
                                        - 64'(NUM_SETS))) / 64'(NUM_SETS)) + 64'd1);

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_HASH = 5'b00010,
        F_SUM  = 5'b00100,
        F_MOD  = 5'b01000,
        F_PUSH = 5'b10000
    } fstate_t;

    fstate_t                       state_reg, state_next;
    req_t                          req_reg;
    logic [CHAR_SLOTS:0][15:0]     sh_reg;
    logic [3:0]                    rl_reg;
    logic [7:0]                    even_reg;
    logic [7:0]                    odd_reg;
    logic                          stop_reg;
    logic [4:0]                    cnt_reg;
    logic [SUM_BITS-1:0]           sum_reg;
    logic [31:0]                   t1_reg;
    logic [31:0]                   quo_reg;
    logic [SW-1:0]                 rem_reg;
    name_t                         folded;
    logic [CHAR_SLOTS*16-1:0]      name_all;
    logic [63:0]                   prod;
    logic [31:0]                   q_calc;
    logic [31:0]                   qn;
    logic [31:0]                   rem_calc;
    logic                          stop_a;
    logic                          stop_b;
    logic [7:0]                    even_next;
    logic [7:0]                    odd_next;
    logic                          ign;

    assign full     = (state_reg != F_IDLE);
    assign name_all = {req.name_w3, req.name_w2, req.name_w1, req.name_w0};
    assign ign      = (req.action != ACT_PURGE)
                      && ((req.name_len == 8'd0) || (req.name_len > 8'(MAX_NAME)));

    always_comb
    begin
        logic [15:0] c;
        for (int k = 0; k < CHAR_SLOTS; k++)
        begin
            c = name_all[16*k +: 16];
            if (case_fold && (c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z))
            begin
                c = c - CHAR_FOLD;
            end
            folded[k] = c;
        end
    end

    always_comb
    begin
        stop_a    = stop_reg;
        even_next = even_reg;
        odd_next  = odd_reg;
        if (!stop_a && (rl_reg != 4'd0))
        begin
            if (sh_reg[0] == 16'h0000)
            begin
                stop_a = 1'b1;
            end
            else
            begin
                even_next = PERM[even_reg ^ sh_reg[0][7:0]];
            end
        end
        stop_b = stop_a;
        if (!stop_a && (rl_reg > 4'd1))
        begin
            if (sh_reg[1] == 16'h0000)
            begin
                stop_b = 1'b1;
            end
            else
            begin
                odd_next = PERM[odd_reg ^ sh_reg[1][7:0]];
            end
        end
    end

    assign prod     = {32'd0, sum_reg} * {32'd0, RECIP_M};
    assign q_calc   = (t1_reg + ((sum_reg - t1_reg) >> 1)) >> RECIP_SH;
    assign qn       = quo_reg * 32'(NUM_SETS);
    assign rem_calc = sum_reg - qn;

    always_comb
    begin
        state_next = state_reg;
        q_push     = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    state_next = (ign || (req.action == ACT_PURGE)) ? F_PUSH : F_HASH;
                end
            end
            F_HASH:
            begin
                if (cnt_reg == 5'(HASH_STEPS - 1))
                begin
                    state_next = F_SUM;
                end
            end
            F_SUM:
            begin
                state_next = F_MOD;
            end
            F_MOD:
            begin
                if (cnt_reg == 5'(MOD_STEPS - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign q_req = req_reg;
    assign q_set = rem_reg;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                req_reg.action  <= req.action;
                req_reg.ignore  <= ign;
                req_reg.volume  <= req.volume_id;
                req_reg.dir     <= req.dir_ino;
                req_reg.len     <= req.name_len[3:0];
                req_reg.chars   <= folded;
                req_reg.new_ino <= req.new_ino;
                sh_reg          <= {16'h0000, folded};
                rl_reg          <= req.name_len[3:0];
                even_reg        <= 8'h00;
                odd_reg         <= 8'h00;
                stop_reg        <= 1'b0;
                rem_reg         <= '0;
            end
            F_HASH:
            begin
                sh_reg   <= sh_reg >> 32;
                rl_reg   <= (rl_reg > 4'd2) ? rl_reg - 4'd2 : 4'd0;
                even_reg <= even_next;
                odd_reg  <= odd_next;
                stop_reg <= stop_b;
            end
            F_SUM:
            begin
                sum_reg <= {16'h0000, odd_reg, even_reg} + req_reg.volume + req_reg.dir;
                rem_reg <= '0;
            end
            F_MOD:
            begin
                if (cnt_reg == 5'd0)
                begin
                    t1_reg <= prod[63:32];
                end
                else if (cnt_reg == 5'd1)
                begin
                    quo_reg <= q_calc;
                end
                else
                begin
                    rem_reg <= (NUM_SETS == 1) ? '0 : rem_calc[SW-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg != state_next)
            begin
                cnt_reg <= 5'd0;
            end
            else if ((state_reg == F_HASH) || (state_reg == F_MOD))
            begin
                cnt_reg <= cnt_reg + 5'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/dnlc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dnlc_back
// Reads a set, matches, updates recency and entries, writes the set back.
// ----------------------------------------------------------------------------
module dnlc_back
    import dnlc_pkg::*;
#(
    parameter int NUM_SETS = NUM_SETS_DEF,
    parameter int NUM_WAYS = NUM_WAYS_DEF,
    parameter int SW       = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire req_t          q_req,
    input  wire logic [SW-1:0] q_set,
    output logic               q_pop,
    input  wire logic          r_full,
    output logic               r_push,
    output out_item_t          r_item
);

    localparam int RW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

    typedef enum logic [5:0] {
        B_CLEAR = 6'b000001,
        B_IDLE  = 6'b000010,
        B_RD    = 6'b000100,
        B_EXE   = 6'b001000,
        B_PRD   = 6'b010000,
        B_PEXE  = 6'b100000
    } bstate_t;

    typedef logic [NUM_WAYS-1:0][RW-1:0] rank_row_t;
    typedef way_t [NUM_WAYS-1:0]         data_row_t;

    logic [NUM_WAYS-1:0] valid_mem [NUM_SETS];
    rank_row_t           rank_mem  [NUM_SETS];
    data_row_t           data_mem  [NUM_SETS];

    bstate_t             state_reg, state_next;
    logic [SW-1:0]       addr_reg, addr_next;
    req_t                req_reg;
    logic [NUM_WAYS-1:0] valid_rd_reg;
    rank_row_t           rank_rd_reg;
    data_row_t           data_rd_reg;

    logic                mwe;
    logic [SW-1:0]       maddr;
    logic [NUM_WAYS-1:0] wvalid;
    rank_row_t           wrank;
    logic                dwe;
    data_row_t           wdata;
    rank_row_t           init_rank;
    logic [NUM_WAYS-1:0] match;
    logic [NUM_WAYS-1:0] pm;
    logic                found;
    logic [RW-1:0]       fw;
    logic [RW-1:0]       victim;
    logic [RW-1:0]       tgt;
    rank_row_t           nr_front;
    rank_row_t           nr_back;
    rank_row_t           nr_purge;
    logic                last_set;

    assign last_set = (addr_reg == SW'(NUM_SETS - 1));

    always_comb
    begin
        logic          eq;
        logic [RW-1:0] best;
        logic [RW-1:0] worst;
        logic [RW-1:0] rt;
        logic [RW:0]   nk;
        logic [RW:0]   np;
        logic [RW:0]   totk;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            init_rank[w] = RW'(w);
            eq = valid_rd_reg[w]
                 && (data_rd_reg[w].volume == req_reg.volume)
                 && (data_rd_reg[w].dir == req_reg.dir)
                 && (data_rd_reg[w].len == req_reg.len);
            for (int c = 0; c < CHAR_SLOTS; c++)
            begin
                if ((4'(c) < req_reg.len) && (data_rd_reg[w].chars[c] != req_reg.chars[c]))
                begin
                    eq = 1'b0;
                end
            end
            match[w] = eq;
            pm[w]    = valid_rd_reg[w] && (data_rd_reg[w].volume == req_reg.volume);
        end
        found  = 1'b0;
        fw     = '0;
        best   = '0;
        victim = '0;
        worst  = '0;
        totk   = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (match[w] && (!found || (rank_rd_reg[w] < best)))
            begin
                found = 1'b1;
                fw    = RW'(w);
                best  = rank_rd_reg[w];
            end
            if (rank_rd_reg[w] >= worst)
            begin
                worst  = rank_rd_reg[w];
                victim = RW'(w);
            end
            if (!pm[w])
            begin
                totk = totk + (RW+1)'(1);
            end
        end
        tgt = found ? fw : victim;
        rt  = rank_rd_reg[tgt];
        for (int k = 0; k < NUM_WAYS; k++)
        begin
            if (RW'(k) == tgt)
            begin
                nr_front[k] = '0;
                nr_back[k]  = RW'(NUM_WAYS - 1);
            end
            else
            begin
                nr_front[k] = (rank_rd_reg[k] < rt) ? rank_rd_reg[k] + RW'(1) : rank_rd_reg[k];
                nr_back[k]  = (rank_rd_reg[k] > rt) ? rank_rd_reg[k] - RW'(1) : rank_rd_reg[k];
            end
            nk = '0;
            np = '0;
            for (int j = 0; j < NUM_WAYS; j++)
            begin
                if (rank_rd_reg[j] < rank_rd_reg[k])
                begin
                    if (pm[j])
                    begin
                        np = np + (RW+1)'(1);
                    end
                    else
                    begin
                        nk = nk + (RW+1)'(1);
                    end
                end
            end
            nr_purge[k] = pm[k] ? RW'(totk + np) : RW'(nk);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        q_pop      = 1'b0;
        r_push     = 1'b0;
        r_item     = '0;
        mwe        = 1'b0;
        maddr      = addr_reg;
        wvalid     = valid_rd_reg;
        wrank      = rank_rd_reg;
        dwe        = 1'b0;
        wdata      = data_rd_reg;
        case (state_reg)
            B_CLEAR:
            begin
                mwe    = 1'b1;
                wvalid = '0;
                wrank  = init_rank;
                addr_next = addr_reg + SW'(1);
                if (last_set)
                begin
                    addr_next  = '0;
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!q_empty && !r_full)
                begin
                    q_pop = 1'b1;
                    if (q_req.ignore)
                    begin
                        r_push = 1'b1;
                    end
                    else if (q_req.action == ACT_PURGE)
                    begin
                        addr_next  = '0;
                        state_next = B_PRD;
                    end
                    else
                    begin
                        addr_next  = q_set;
                        state_next = B_RD;
                    end
                end
            end
            B_RD:
            begin
                state_next = B_EXE;
            end
            B_EXE:
            begin
                r_push     = 1'b1;
                r_item.hit = found;
                state_next = B_IDLE;
                case (req_reg.action)
                    ACT_LOOKUP:
                    begin
                        if (found)
                        begin
                            r_item.found_ino = data_rd_reg[fw].ino;
                            mwe   = 1'b1;
                            wrank = nr_front;
                        end
                    end
                    ACT_ENTER:
                    begin
                        mwe   = 1'b1;
                        wrank = nr_front;
                        if (!found)
                        begin
                            dwe                 = 1'b1;
                            wvalid[victim]      = 1'b1;
                            wdata[victim].volume = req_reg.volume;
                            wdata[victim].dir   = req_reg.dir;
                            wdata[victim].ino   = req_reg.new_ino;
                            wdata[victim].len   = req_reg.len;
                            wdata[victim].chars = req_reg.chars;
                        end
                    end
                    ACT_DELETE:
                    begin
                        if (found)
                        begin
                            mwe        = 1'b1;
                            wvalid[fw] = 1'b0;
                            wrank      = nr_back;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            B_PRD:
            begin
                state_next = B_PEXE;
            end
            B_PEXE:
            begin
                mwe    = 1'b1;
                wvalid = valid_rd_reg & ~pm;
                wrank  = nr_purge;
                if (last_set)
                begin
                    r_push     = 1'b1;
                    state_next = B_IDLE;
                end
                else
                begin
                    addr_next  = addr_reg + SW'(1);
                    state_next = B_PRD;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mwe)
        begin
            valid_mem[maddr] <= wvalid;
            rank_mem[maddr]  <= wrank;
        end
        if (dwe)
        begin
            data_mem[addr_reg] <= wdata;
        end
        valid_rd_reg <= valid_mem[addr_reg];
        rank_rd_reg  <= rank_mem[addr_reg];
        data_rd_reg  <= data_mem[addr_reg];
        if (q_pop)
        begin
            req_reg <= q_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/directory_name_lookup_cache_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// directory_name_lookup_cache_core
// Set-associative directory name cache with LRU replacement per set.
// ----------------------------------------------------------------------------
// Input beats enter through push/full, one result beat per request leaves
// through empty/pop in request order. The front folds case as it accepts a
// beat, then is busy while it hashes the name, one character pair per cycle,
// forms the sum and reduces it to a set by reciprocal multiplication, then
// hands it on once the queue has room; it takes no new beat until then.
// Purge and ignored names skip hashing and go straight to the hand-on state.
// A two-entry queue decouples it from the back, which reads the set in
// B_RD and writes it back in B_EXE.
// Purge walks every set, reading it in B_PRD and writing it in B_PEXE.
// Ignored names are answered from the back's idle state without a set read.
// After reset the back clears valid bits and recency one set a cycle;
// requests queue up meanwhile. case_fold resets to 1.
// When the receiver stalls, results wait in a two-entry output queue and the
// back holds before its next request until a slot frees.
// ----------------------------------------------------------------------------
module directory_name_lookup_cache_core
    import dnlc_pkg::*;
#(
    parameter int NUM_SETS = NUM_SETS_DEF,
    parameter int NUM_WAYS = NUM_WAYS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire in_item_t    req,
    output logic             full,
    output logic             empty,
    input  wire logic        pop,
    output out_item_t        rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

    logic          case_fold_reg;
    logic          cfg_wr;
    logic          mid_push;
    req_t          mid_wreq;
    logic [SW-1:0] mid_wset;
    logic          mid_full;
    logic          mid_empty;
    logic          mid_pop;
    req_t          mid_rreq;
    logic [SW-1:0] mid_rset;
    logic          res_full;
    logic          res_push;
    out_item_t     res_item;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (8'(paddr[2]) == REG_CASE_FOLD);
    assign prdata = (8'(paddr[2]) == REG_CASE_FOLD) ? {31'd0, case_fold_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            case_fold_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            case_fold_reg <= pwdata[0];
        end
    end

    dnlc_front #(.NUM_SETS(NUM_SETS), .SW(SW)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .case_fold (case_fold_reg),
        .push      (push),
        .req       (req),
        .full      (full),
        .q_push    (mid_push),
        .q_req     (mid_wreq),
        .q_set     (mid_wset),
        .q_full    (mid_full)
    );

    dnlc_fifo #(.WIDTH($bits(req_t) + SW)) u_mid_q
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (mid_push),
        .wdata ({mid_wreq, mid_wset}),
        .full  (mid_full),
        .rd    (mid_pop),
        .rdata ({mid_rreq, mid_rset}),
        .empty (mid_empty)
    );

    dnlc_back #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .SW(SW)) u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (mid_empty),
        .q_req   (mid_rreq),
        .q_set   (mid_rset),
        .q_pop   (mid_pop),
        .r_full  (res_full),
        .r_push  (res_push),
        .r_item  (res_item)
    );

    dnlc_fifo #(.WIDTH($bits(out_item_t))) u_res_q
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_push),
        .wdata (res_item),
        .full  (res_full),
        .rd    (pop),
        .rdata (rsp),
        .empty (empty)
    );

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> full)
        else $error("front accepted a beat but did not go busy");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (case_fold_reg == $past(pwdata[0])))
        else $error("case_fold not updated by write");

    a_mid_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        mid_push |-> !mid_full)
        else $error("front pushed into a full queue");

    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("back pushed into a full result queue");
`endif

endmodule
`default_nettype wire
